[hw/rtl/assert_macros.svh]
// assertion macros used by the pusher unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, off while in reset
`define AST_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
// next-cycle implication, off while in reset
`define AST_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
// next-cycle implication, checked during reset too
`define AST_NEXT_ALWAYS(lbl, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) else $error("lbl");
`else
`define AST_IMPL(lbl, a, b)
`define AST_NEXT(lbl, a, b)
`define AST_NEXT_ALWAYS(lbl, a, b)
`endif
`endif

[hw/rtl/bpp_pkg.sv]
// types, constants and arithmetic helpers of the boris particle pusher
`timescale 1ns / 1ps
package bpp_pkg;

  localparam int CFG_IDX_W = 1;
  localparam int QUOT_W    = 18;
  localparam int DEN_W     = 48;
  localparam int REM_W     = DEN_W + QUOT_W;
  localparam int DIV_FIRST = 4;
  localparam int NUM_STG   = DIV_FIRST + QUOT_W + 7;
  localparam logic [DEN_W-1:0] Q_ONE   = DEN_W'(65536);
  localparam logic [REM_W-1:0] TWO_Q16 = REM_W'(64'h2_0000_0000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_STEP = 1'b0,
    REG_POS_SCALE = 1'b1
  } cfg_reg_t;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    vec3_t             vel;
    logic [31:0]       pos;
    vec3_t             kick;
    vec3_t             tv;
    vec3_t             um;
    vec3_t             pd;
    vec3_t             sv;
    vec3_t             nv;
    logic [8:0][63:0]  prod;
    logic [DEN_W-1:0]  den;
    logic [REM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
  } item_t;

  // exact signed 32x32 product
  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic signed [63:0] r;
    r = $signed(a) * $signed(b);
    return r;
  endfunction

  // q16.16 rounding of a product: add half lsb, floor shift
  function automatic logic signed [63:0] rnd(input logic [63:0] p);
    logic signed [63:0] t;
    t = $signed(p) + 64'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic signed [63:0] ext(input logic [31:0] a);
    return 64'($signed(a));
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

[hw/rtl/bpp_if.sv]
// valid/ready channels of the particle pusher
`timescale 1ns / 1ps

interface bpp_particle_if;
  logic        valid;
  logic        ready;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic [31:0] pos_x;
  logic [31:0] field_ex;
  logic [31:0] field_ey;
  logic [31:0] field_ez;
  logic [31:0] field_bx;
  logic [31:0] field_by;
  logic [31:0] field_bz;
  modport source (output valid, vel_x, vel_y, vel_z, pos_x, field_ex, field_ey, field_ez,
                  field_bx, field_by, field_bz, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, pos_x, field_ex, field_ey, field_ez,
                field_bx, field_by, field_bz, output ready);
endinterface

interface bpp_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_vel_x;
  logic [31:0] new_vel_y;
  logic [31:0] new_vel_z;
  logic [31:0] new_pos_x;
  modport source (output valid, new_vel_x, new_vel_y, new_vel_z, new_pos_x, input ready);
  modport sink (input valid, new_vel_x, new_vel_y, new_vel_z, new_pos_x, output ready);
endinterface

interface bpp_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/boris_particle_pusher_unit.sv]
// boris particle pusher: pipelined non-relativistic velocity and position update
`timescale 1ns / 1ps
// usage:
//   particle: one particle per beat (velocity, position, e and b field), valid/ready
//   result:   one beat per particle (new velocity, new position), valid/ready
//   cfg:      register writes, always ready; index 0 half_step_ratio, 1 position_scale,
//             write only while no particle is in flight
// timing:
//   29 register stages from an accepted beat to its result beat; one particle per cycle
//   sustained while results are taken. the 18 stages of the restoring divider for
//   2/(1+|T|^2), one quotient bit a stage, set most of the depth; each multiply stage holds 32x32 multipliers.
// stall:
//   the whole pipe moves together; while the last stage holds an untaken result the
//   pipe freezes and particle.ready drops, so nothing is lost or repeated. a taken
//   result frees the last stage in the same cycle, so the pipe keeps streaming.
// reset:
//   synchronous rst clears all stage valid bits and both config registers to zero;
//   the stage data registers are not reset; every particle is independent.
`include "assert_macros.svh"
module boris_particle_pusher_unit
  import bpp_pkg::*;
(
  input logic            clk,
  input logic            rst,
  bpp_particle_if.sink   particle,
  bpp_result_if.source   result,
  bpp_cfg_if.sink        cfg
);

  logic [31:0] half_step_ratio;
  logic [31:0] position_scale;

  item_t                pipe      [NUM_STG];
  item_t                pipe_next [NUM_STG];
  logic [NUM_STG-1:0]   vld;
  logic                 en;

  // pipe advances whenever the output stage is empty or being drained
  assign en             = !vld[NUM_STG-1] || result.ready;
  assign particle.ready = en;
  assign cfg.ready      = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_ratio <= '0;
      position_scale  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_HALF_STEP: half_step_ratio <= cfg.data;
        REG_POS_SCALE: position_scale  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_STG; i++) begin
      pipe_next[i] = (i == 0) ? '0 : pipe[(i == 0) ? 0 : i - 1];
    end

    // stage 0: capture and the h*E, h*B products
    pipe_next[0].vel     = {particle.vel_z, particle.vel_y, particle.vel_x};
    pipe_next[0].pos     = particle.pos_x;
    pipe_next[0].prod[0] = mul32(half_step_ratio, particle.field_ex);
    pipe_next[0].prod[1] = mul32(half_step_ratio, particle.field_ey);
    pipe_next[0].prod[2] = mul32(half_step_ratio, particle.field_ez);
    pipe_next[0].prod[3] = mul32(half_step_ratio, particle.field_bx);
    pipe_next[0].prod[4] = mul32(half_step_ratio, particle.field_by);
    pipe_next[0].prod[5] = mul32(half_step_ratio, particle.field_bz);

    // stage 1: kick, T and the first half kick
    for (int c = 0; c < 3; c++) begin
      pipe_next[1].kick[c] = sat32(rnd(pipe[0].prod[c]));
      pipe_next[1].tv[c]   = sat32(rnd(pipe[0].prod[c+3]));
      pipe_next[1].um[c]   = sat32(ext(pipe[0].vel[c]) + ext(pipe_next[1].kick[c]));
    end

    // stage 2: squares of T and the six um x T products
    for (int c = 0; c < 3; c++) begin
      pipe_next[2].prod[c] = mul32(pipe[1].tv[c], pipe[1].tv[c]);
    end
    pipe_next[2].prod[3] = mul32(pipe[1].um[1], pipe[1].tv[2]);
    pipe_next[2].prod[4] = mul32(pipe[1].um[2], pipe[1].tv[1]);
    pipe_next[2].prod[5] = mul32(pipe[1].um[2], pipe[1].tv[0]);
    pipe_next[2].prod[6] = mul32(pipe[1].um[0], pipe[1].tv[2]);
    pipe_next[2].prod[7] = mul32(pipe[1].um[0], pipe[1].tv[1]);
    pipe_next[2].prod[8] = mul32(pipe[1].um[1], pipe[1].tv[0]);

    // stage 3: denominator, p-dot and the divider's start value
    pipe_next[3].den   = Q_ONE + DEN_W'(rnd(pipe[2].prod[0]))
                       + DEN_W'(rnd(pipe[2].prod[1])) + DEN_W'(rnd(pipe[2].prod[2]));
    pipe_next[3].pd[0] = sat32(ext(pipe[2].um[0]) + rnd(pipe[2].prod[3])
                       - rnd(pipe[2].prod[4]));
    pipe_next[3].pd[1] = sat32(ext(pipe[2].um[1]) + rnd(pipe[2].prod[5])
                       - rnd(pipe[2].prod[6]));
    pipe_next[3].pd[2] = sat32(ext(pipe[2].um[2]) + rnd(pipe[2].prod[7])
                       - rnd(pipe[2].prod[8]));
    pipe_next[3].rem   = TWO_Q16 + REM_W'(pipe_next[3].den >> 1);
    pipe_next[3].quot  = '0;

    // divider: one quotient bit per stage, msb first
    for (int d = 0; d < QUOT_W; d++) begin
      pipe_next[DIV_FIRST+d] = pipe[DIV_FIRST+d-1];
      if (pipe[DIV_FIRST+d-1].rem >=
          (REM_W'(pipe[DIV_FIRST+d-1].den) << (QUOT_W - 1 - d))) begin
        pipe_next[DIV_FIRST+d].rem = pipe[DIV_FIRST+d-1].rem
                                   - (REM_W'(pipe[DIV_FIRST+d-1].den) << (QUOT_W - 1 - d));
        pipe_next[DIV_FIRST+d].quot[QUOT_W-1-d] = 1'b1;
      end
    end

    // T * inv
    for (int c = 0; c < 3; c++) begin
      pipe_next[DIV_FIRST+QUOT_W].prod[c] =
        mul32(pipe[DIV_FIRST+QUOT_W-1].tv[c], 32'(pipe[DIV_FIRST+QUOT_W-1].quot));
    end

    // S
    for (int c = 0; c < 3; c++) begin
      pipe_next[DIV_FIRST+QUOT_W+1].sv[c] = sat32(rnd(pipe[DIV_FIRST+QUOT_W].prod[c]));
    end

    // p-dot x S products
    pipe_next[DIV_FIRST+QUOT_W+2].prod[0] =
      mul32(pipe[DIV_FIRST+QUOT_W+1].pd[1], pipe[DIV_FIRST+QUOT_W+1].sv[2]);
    pipe_next[DIV_FIRST+QUOT_W+2].prod[1] =
      mul32(pipe[DIV_FIRST+QUOT_W+1].pd[2], pipe[DIV_FIRST+QUOT_W+1].sv[1]);
    pipe_next[DIV_FIRST+QUOT_W+2].prod[2] =
      mul32(pipe[DIV_FIRST+QUOT_W+1].pd[2], pipe[DIV_FIRST+QUOT_W+1].sv[0]);
    pipe_next[DIV_FIRST+QUOT_W+2].prod[3] =
      mul32(pipe[DIV_FIRST+QUOT_W+1].pd[0], pipe[DIV_FIRST+QUOT_W+1].sv[2]);
    pipe_next[DIV_FIRST+QUOT_W+2].prod[4] =
      mul32(pipe[DIV_FIRST+QUOT_W+1].pd[0], pipe[DIV_FIRST+QUOT_W+1].sv[1]);
    pipe_next[DIV_FIRST+QUOT_W+2].prod[5] =
      mul32(pipe[DIV_FIRST+QUOT_W+1].pd[1], pipe[DIV_FIRST+QUOT_W+1].sv[0]);

    // u-plus, held in nv
    for (int c = 0; c < 3; c++) begin
      pipe_next[DIV_FIRST+QUOT_W+3].nv[c] = sat32(ext(pipe[DIV_FIRST+QUOT_W+2].um[c])
        + rnd(pipe[DIV_FIRST+QUOT_W+2].prod[2*c])
        - rnd(pipe[DIV_FIRST+QUOT_W+2].prod[2*c+1]));
    end

    // second half kick
    for (int c = 0; c < 3; c++) begin
      pipe_next[DIV_FIRST+QUOT_W+4].nv[c] = sat32(ext(pipe[DIV_FIRST+QUOT_W+3].nv[c])
        + ext(pipe[DIV_FIRST+QUOT_W+3].kick[c]));
    end

    // position step product
    pipe_next[DIV_FIRST+QUOT_W+5].prod[0] =
      mul32(position_scale, pipe[DIV_FIRST+QUOT_W+4].nv[0]);

    // new position, output stage
    pipe_next[DIV_FIRST+QUOT_W+6].pos = sat32(ext(pipe[DIV_FIRST+QUOT_W+5].pos)
      + rnd(pipe[DIV_FIRST+QUOT_W+5].prod[0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STG-2:0], particle.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_STG; i++) begin
        pipe[i] <= pipe_next[i];
      end
    end
  end

  assign result.valid     = vld[NUM_STG-1];
  assign result.new_vel_x = pipe[NUM_STG-1].nv[0];
  assign result.new_vel_y = pipe[NUM_STG-1].nv[1];
  assign result.new_vel_z = pipe[NUM_STG-1].nv[2];
  assign result.new_pos_x = pipe[NUM_STG-1].pos;

  `AST_NEXT_ALWAYS(a_reset_empties, rst, vld == '0)
  `AST_NEXT(a_accept_enters, particle.valid && particle.ready, vld[0])
  `AST_NEXT(a_stall_freezes, vld[NUM_STG-1] && !result.ready, $stable(vld))
  `AST_IMPL(a_den_at_least_one, vld[DIV_FIRST-1], pipe[DIV_FIRST-1].den >= Q_ONE)

endmodule

[sim/tb_top.sv]
// testbench for the boris particle pusher: directed and random particles checked against a local predictor
`timescale 1ns / 1ps
module tb_top
  import bpp_pkg::*;
();

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  bpp_particle_if particle();
  bpp_result_if   result();
  bpp_cfg_if      cfg();

  boris_particle_pusher_unit DUT (
    .clk(clk), .rst(rst), .particle(particle), .result(result), .cfg(cfg)
  );

  typedef struct packed {
    logic [31:0] vx, vy, vz, px;
  } push_out_t;

  // predicted pusher outputs, oldest first
  class push_scoreboard;
    logic signed [63:0] qm_half;
    logic signed [63:0] cell_scale;
    push_out_t pending[$];
    int errors;

    function new();
      qm_half = 0;
      cell_scale = 0;
      errors = 0;
    endfunction

    // q16.16 product, round half up, floor shift, no clamp
    function logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b + 64'sd32768;
      return p >>> 16;
    endfunction

    function logic signed [63:0] clamp(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] d);
      if (idx == REG_HALF_STEP) qm_half = 64'($signed(d));
      else cell_scale = 64'($signed(d));
    endfunction

    // boris push of one particle
    function void note_particle(logic [9:0][31:0] f);
      logic signed [63:0] v[3], e[3], b[3], k[3], t[3], s[3], um[3], pd[3], up[3], nv[3];
      logic signed [63:0] x, den, inv, pnew;
      push_out_t o;
      for (int i = 0; i < 3; i++) begin
        v[i] = 64'($signed(f[i]));
        e[i] = 64'($signed(f[4 + i]));
        b[i] = 64'($signed(f[7 + i]));
      end
      x = 64'($signed(f[3]));
      for (int i = 0; i < 3; i++) begin
        k[i] = clamp(qmul(qm_half, e[i]));
        t[i] = clamp(qmul(qm_half, b[i]));
        um[i] = clamp(v[i] + k[i]);
      end
      den = 64'sd65536 + qmul(t[0], t[0]) + qmul(t[1], t[1]) + qmul(t[2], t[2]);
      inv = ((64'sd1 <<< 33) + den / 2) / den;
      for (int i = 0; i < 3; i++) s[i] = clamp(qmul(t[i], inv));
      pd[0] = clamp(um[0] + qmul(um[1], t[2]) - qmul(um[2], t[1]));
      pd[1] = clamp(um[1] + qmul(um[2], t[0]) - qmul(um[0], t[2]));
      pd[2] = clamp(um[2] + qmul(um[0], t[1]) - qmul(um[1], t[0]));
      up[0] = clamp(um[0] + qmul(pd[1], s[2]) - qmul(pd[2], s[1]));
      up[1] = clamp(um[1] + qmul(pd[2], s[0]) - qmul(pd[0], s[2]));
      up[2] = clamp(um[2] + qmul(pd[0], s[1]) - qmul(pd[1], s[0]));
      for (int i = 0; i < 3; i++) nv[i] = clamp(up[i] + k[i]);
      o.vx = nv[0][31:0];
      o.vy = nv[1][31:0];
      o.vz = nv[2][31:0];
      pnew = clamp(x + qmul(cell_scale, nv[0]));
      o.px = pnew[31:0];
      pending = {pending, o};
    endfunction

    function void check_result(push_out_t got);
      push_out_t exp_o;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending: %h", got);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got.vx !== exp_o.vx) begin
        $error("new_vel_x exp %h got %h", exp_o.vx, got.vx); errors++;
      end
      if (got.vy !== exp_o.vy) begin
        $error("new_vel_y exp %h got %h", exp_o.vy, got.vy); errors++;
      end
      if (got.vz !== exp_o.vz) begin
        $error("new_vel_z exp %h got %h", exp_o.vz, got.vz); errors++;
      end
      if (got.px !== exp_o.px) begin
        $error("new_pos_x exp %h got %h", exp_o.px, got.px); errors++;
      end
    endfunction
  endclass

  push_scoreboard sb = new();

  localparam int DRAIN_CYCLES = NUM_STG + 20;
  localparam int IDLE_LIMIT   = 5000;

  int idle_cycles = 0;
  int stall_mode = 0;
  bit drain_stall_off = 0;

  initial begin
    particle.valid = 1'b0;
    {particle.vel_x, particle.vel_y, particle.vel_z, particle.pos_x} = '0;
    {particle.field_ex, particle.field_ey, particle.field_ez} = '0;
    {particle.field_bx, particle.field_by, particle.field_bz} = '0;
    result.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
  end

  // monitor: sample at the rising edge, note inputs and check outputs
  always @(posedge clk) begin
    if (!rst) begin
      if (particle.valid && particle.ready)
        sb.note_particle({particle.field_bz, particle.field_by, particle.field_bx,
                          particle.field_ez, particle.field_ey, particle.field_ex,
                          particle.pos_x, particle.vel_z, particle.vel_y, particle.vel_x});
      if (result.valid && result.ready)
        sb.check_result({result.new_vel_x, result.new_vel_y, result.new_vel_z,
                         result.new_pos_x});
      if ((particle.valid && particle.ready) || (result.valid && result.ready) ||
          (cfg.valid && cfg.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog on cycles with no beat anywhere
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result-side stalls: pattern switches between always ready, random and bursty
  int stall_phase = 0;
  always @(negedge clk) begin
    if (!rst) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 2);
      if (drain_stall_off || stall_mode == 0) result.ready <= 1'b1;
      else if (stall_mode == 1) result.ready <= ($urandom_range(0, 3) != 0);
      else result.ready <= ((stall_phase / 5) % 3 != 0);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // wait for every pending result, then let the pipe settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one particle beat; valid held across back-to-back beats, else dropped before the next beat
  task automatic send_particle(logic [9:0][31:0] f, bit keep_valid);
    particle.valid <= 1'b1;
    particle.vel_x <= f[0];
    particle.vel_y <= f[1];
    particle.vel_z <= f[2];
    particle.pos_x <= f[3];
    particle.field_ex <= f[4];
    particle.field_ey <= f[5];
    particle.field_ez <= f[6];
    particle.field_bx <= f[7];
    particle.field_by <= f[8];
    particle.field_bz <= f[9];
    @(posedge clk);
    while (!particle.ready) @(posedge clk);
    @(negedge clk);
    if (!keep_valid) begin
      particle.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_word(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
      3: return ($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    endcase
  endfunction

  task automatic random_burst(int count);
    logic [9:0][31:0] f;
    int left;
    int kind;
    left = count;
    while (left > 0) begin
      int burst;
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      for (int n = 0; n < burst; n++) begin
        for (int j = 0; j < 10; j++) begin
          kind = $urandom_range(0, 9);
          f[j] = rand_word(kind < 2 ? 0 : kind < 5 ? 1 : kind < 7 ? 2 : kind < 8 ? 3 : 4);
        end
        send_particle(f, n != burst - 1);
      end
      left -= burst;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  logic [31:0] ratios[6] = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
                             32'h0000_8000, 32'hffff_c000, 32'h0000_0100};
  logic [31:0] scales[6] = '{32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff,
                             32'h0001_0000, 32'h0000_4000, 32'hfffe_0000};

  initial begin
    logic [9:0][31:0] f;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zeros, extremes, unit rotation, saturating fields
    write_reg(REG_HALF_STEP, 32'h0000_8000);
    write_reg(REG_POS_SCALE, 32'h0001_0000);
    f = '0;
    send_particle(f, 0);
    f = {10{32'h7fff_ffff}};
    send_particle(f, 0);
    f = {10{32'h8000_0000}};
    send_particle(f, 0);
    f = '0; f[0] = 32'h0001_0000; f[9] = 32'h0002_0000;
    send_particle(f, 0);
    f = '0; f[1] = 32'hffff_0000; f[7] = 32'h0100_0000; f[4] = 32'h7fff_ffff;
    send_particle(f, 0);
    f = '0; f[0] = 32'h7fff_ffff; f[6] = 32'h7fff_ffff; f[8] = 32'h8000_0000;
    send_particle(f, 0);
    f = '0; f[3] = 32'h7fff_0000; f[0] = 32'h7000_0000;
    send_particle(f, 0);
    f = {32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
         32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa};
    send_particle(f, 0);
    f = ~f;
    send_particle(f, 0);
    // sender holds off until the pipe is empty
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(REG_HALF_STEP, ph < 6 ? ratios[ph] : $urandom_range(0, 1) ?
                32'($signed($urandom_range(0, 1 << 17)) - (1 << 16)) : $urandom());
      write_reg(REG_POS_SCALE, ph < 6 ? scales[ph] : $urandom());
      drain_stall_off = (ph == 3);
      random_burst(50);
      drain();
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/bpp_pkg.sv
hw/rtl/bpp_if.sv
hw/rtl/boris_particle_pusher_unit.sv
sim/tb_top.sv
